// ----- src/auction_task_allocator_core_defines.svh -----
// Assertion macros shared by the auction task allocator RTL.
// No dependencies; expects i_clk and i_rst_n in the including scope.
`ifndef AUCTION_TASK_ALLOCATOR_CORE_DEFINES_SVH
`define AUCTION_TASK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ATA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ATA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ata_pkg.sv -----
// Shared constants, codes and types of the auction task allocator.
// No dependencies.
package ata_pkg;

    localparam int ROBOT_SLOTS = 16;
    localparam int TASK_SLOTS  = 64;

    localparam int RB_W  = (ROBOT_SLOTS > 1) ? $clog2(ROBOT_SLOTS) : 1;
    localparam int TK_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    localparam logic [15:0] BID_IDLE  = 16'd25600;
    localparam logic [1:0]  PAIR_NEED = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_ACTIVE   = 2'd1,
        CMD_BID      = 2'd2,
        CMD_COMPLETE = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_OFFER    = 2'd0;
    localparam logic [1:0] KIND_WIN      = 2'd1;
    localparam logic [1:0] KIND_ALL_DONE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_START,
        ST_SRCH,
        ST_PICK_RD,
        ST_PICK_SCAN
    } t_state;

    typedef struct packed {
        logic       done;
        logic [1:0] need;
        logic [7:0] weight;
    } t_task_entry;

    typedef struct packed {
        logic [15:0] cost;
        logic [15:0] strength;
    } t_bid_entry;

endpackage

// ----- src/ata_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ata_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/auction_task_allocator_core.sv -----
// Auction task allocator top level: command decode, task search and winner scan.
// Depends on ata_pkg, ata_ram and auction_task_allocator_core_defines.svh.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   i_cmd selects load task, set active robots, robot bid or task completed.
//   Non-final loads, active-count writes and bids that do not close a round
//   leave busy low. A result is registered when its transaction completes
//   and marked by o_valid, which is high for exactly one cycle.
//   Task search reads the task RAM one slot per cycle. Closing a bid round
//   scans the bid RAM one robot slot per cycle, then runs a task search if
//   nobody wins.
//   Reset clears all control state and the bid valid bits at once; there is
//   no clearing pass, the block is ready the cycle after reset is released.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
`include "auction_task_allocator_core_defines.svh"

module auction_task_allocator_core
    import ata_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_robot,
    input  logic [15:0] i_bid_cost,
    input  logic [15:0] i_robot_strength,
    input  logic [7:0]  i_task_weight,
    input  logic [1:0]  i_robots_needed,
    input  logic [4:0]  i_robot_total,
    input  logic        i_final_task,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_task_res,
    output logic [4:0]  o_first_robot,
    output logic [4:0]  o_second_robot
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_load_ptr, n_load_ptr;
    logic [CNT_W-1:0]       r_loaded, n_loaded;
    logic [CNT_W-1:0]       r_fin_cnt, n_fin_cnt;
    logic [TK_W-1:0]        r_cur, n_cur;
    logic                   r_cur_valid, n_cur_valid;
    logic [4:0]             r_bids, n_bids;
    logic [4:0]             r_active, n_active;
    logic [ROBOT_SLOTS-1:0] r_bid_vld, n_bid_vld;

    logic [TK_W-1:0]        r_p, n_p;
    logic [TK_W-1:0]        r_q, n_q;
    logic [TK_W-1:0]        r_chk_q, n_chk_q;
    logic                   r_chk, n_chk;
    logic [CNT_W-1:0]       r_iss, n_iss;
    logic [CNT_W-1:0]       r_kc, n_kc;

    logic [RB_W-1:0]        r_ci, n_ci;
    logic                   r_w1_vld, n_w1_vld;
    logic                   r_w2_vld, n_w2_vld;
    logic [RB_W-1:0]        r_w1, n_w1;
    logic [RB_W-1:0]        r_w2, n_w2;
    logic [15:0]            r_best_cost, n_best_cost;
    logic [15:0]            r_best_str, n_best_str;

    logic                   r_out_vld, n_out_vld;
    logic [1:0]             r_kind, n_kind;
    logic [5:0]             r_task, n_task;
    logic [4:0]             r_first, n_first;
    logic [4:0]             r_second, n_second;

    logic                   task_we;
    logic [TK_W-1:0]        task_waddr, task_raddr;
    t_task_entry            task_wdata, task_rdata;
    logic                   bid_we;
    logic [RB_W-1:0]        bid_waddr, bid_raddr;
    t_bid_entry             bid_wdata, bid_rdata;

    t_bid_entry             cur_bid;
    logic [15:0]            wq;
    logic                   pair;
    logic [16:0]            pair_sum;
    logic [CNT_W-1:0]       lp_inc, fc_inc, p_calc, q_inc;
    logic [4:0]             bids_inc, act_dec1;

    ata_ram #(
        .WIDTH ($bits(t_task_entry)),
        .DEPTH (TASK_SLOTS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (task_wdata),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata)
    );

    ata_ram #(
        .WIDTH ($bits(t_bid_entry)),
        .DEPTH (ROBOT_SLOTS)
    ) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (bid_we),
        .i_waddr (bid_waddr),
        .i_wdata (bid_wdata),
        .i_raddr (bid_raddr),
        .o_rdata (bid_rdata)
    );

    // task RAM output holds the current task's entry for the whole bid scan
    assign wq       = {task_rdata.weight, 8'h00};
    assign pair     = (task_rdata.need == PAIR_NEED);
    assign cur_bid  = r_bid_vld[r_ci] ? bid_rdata :
                      t_bid_entry'{cost: BID_IDLE, strength: 16'd0};
    assign pair_sum = {1'b0, cur_bid.strength} + {1'b0, r_best_str};

    assign lp_inc   = r_load_ptr + CNT_W'(1);
    assign fc_inc   = (r_fin_cnt == {CNT_W{1'b1}}) ? r_fin_cnt : r_fin_cnt + CNT_W'(1);
    assign bids_inc = r_bids + 5'd1;
    assign act_dec1 = (r_active != 5'd0) ? r_active - 5'd1 : 5'd0;
    assign p_calc   = r_cur_valid ? {{(CNT_W-TK_W){1'b0}}, r_cur} + CNT_W'(1) : '0;
    assign q_inc    = {{(CNT_W-TK_W){1'b0}}, r_q} + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_load_ptr  <= '0;
            r_loaded    <= '0;
            r_fin_cnt   <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_bids      <= '0;
            r_active    <= '0;
            r_bid_vld   <= '0;
            r_chk       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_ptr  <= n_load_ptr;
            r_loaded    <= n_loaded;
            r_fin_cnt   <= n_fin_cnt;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_bids      <= n_bids;
            r_active    <= n_active;
            r_bid_vld   <= n_bid_vld;
            r_chk       <= n_chk;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_q         <= n_q;
        r_chk_q     <= n_chk_q;
        r_iss       <= n_iss;
        r_kc        <= n_kc;
        r_ci        <= n_ci;
        r_w1_vld    <= n_w1_vld;
        r_w2_vld    <= n_w2_vld;
        r_w1        <= n_w1;
        r_w2        <= n_w2;
        r_best_cost <= n_best_cost;
        r_best_str  <= n_best_str;
        r_kind      <= n_kind;
        r_task      <= n_task;
        r_first     <= n_first;
        r_second    <= n_second;
    end

    always_comb begin
        n_state     = r_state;
        n_load_ptr  = r_load_ptr;
        n_loaded    = r_loaded;
        n_fin_cnt   = r_fin_cnt;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_bids      = r_bids;
        n_active    = r_active;
        n_bid_vld   = r_bid_vld;
        n_p         = r_p;
        n_q         = r_q;
        n_chk_q     = r_chk_q;
        n_chk       = 1'b0;
        n_iss       = r_iss;
        n_kc        = r_kc;
        n_ci        = r_ci;
        n_w1_vld    = r_w1_vld;
        n_w2_vld    = r_w2_vld;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_best_cost = r_best_cost;
        n_best_str  = r_best_str;
        n_out_vld   = 1'b0;
        n_kind      = r_kind;
        n_task      = r_task;
        n_first     = r_first;
        n_second    = r_second;

        task_we     = 1'b0;
        task_waddr  = r_cur;
        task_wdata  = '{done: 1'b1, need: task_rdata.need, weight: task_rdata.weight};
        task_raddr  = r_cur;
        bid_we      = 1'b0;
        bid_waddr   = RB_W'(i_robot);
        bid_wdata   = '{cost: i_bid_cost, strength: i_robot_strength};
        bid_raddr   = RB_W'(r_ci + RB_W'(1));

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_cmd'(i_cmd))
                        CMD_LOAD: begin
                            if (r_load_ptr < CNT_W'(TASK_SLOTS)) begin
                                task_we    = 1'b1;
                                task_waddr = TK_W'(r_load_ptr);
                                task_wdata = '{done: 1'b0, need: i_robots_needed,
                                               weight: i_task_weight};
                                n_load_ptr = lp_inc;
                            end
                            if (i_final_task) begin
                                n_loaded    = (r_load_ptr < CNT_W'(TASK_SLOTS)) ?
                                              lp_inc : r_load_ptr;
                                n_load_ptr  = '0;
                                n_fin_cnt   = '0;
                                n_cur_valid = 1'b0;
                                n_cur       = '0;
                                n_state     = ST_SRCH_START;
                            end
                        end
                        CMD_ACTIVE: begin
                            n_active = i_robot_total;
                        end
                        CMD_BID: begin
                            if (32'(i_robot) < ROBOT_SLOTS) begin
                                bid_we = 1'b1;
                                n_bid_vld[RB_W'(i_robot)] = 1'b1;
                            end
                            n_bids = bids_inc;
                            if (bids_inc == r_active) begin
                                if (r_cur_valid) begin
                                    n_state = ST_PICK_RD;
                                end else begin
                                    n_bid_vld = '0;
                                    n_bids    = '0;
                                    n_state   = ST_SRCH_START;
                                end
                            end
                        end
                        CMD_COMPLETE: begin
                            n_fin_cnt = fc_inc;
                            if (fc_inc < r_loaded) begin
                                n_state = ST_SRCH_START;
                            end else begin
                                n_out_vld = 1'b1;
                                n_kind    = KIND_ALL_DONE;
                                n_task    = '0;
                                n_first   = '0;
                                n_second  = '0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SRCH_START: begin
                if (r_loaded == '0) begin
                    n_cur_valid = 1'b0;
                    n_cur       = '0;
                    n_state     = ST_IDLE;
                end else begin
                    n_p     = (p_calc >= r_loaded) ? '0 : TK_W'(p_calc);
                    n_q     = (p_calc >= r_loaded) ? '0 : TK_W'(p_calc);
                    n_iss   = '0;
                    n_kc    = '0;
                    n_state = ST_SRCH;
                end
            end

            ST_SRCH: begin
                // issue one slot read per cycle, check the slot read last cycle
                if (r_iss != r_loaded) begin
                    task_raddr = r_q;
                    n_q        = (q_inc >= r_loaded) ? '0 : TK_W'(q_inc);
                    n_iss      = r_iss + CNT_W'(1);
                    n_chk      = 1'b1;
                end
                n_chk_q = r_q;
                if (r_chk) begin
                    if (!task_rdata.done) begin
                        n_cur       = r_chk_q;
                        n_cur_valid = 1'b1;
                        n_out_vld   = 1'b1;
                        n_kind      = KIND_OFFER;
                        n_task      = 6'(r_chk_q);
                        n_first     = '0;
                        n_second    = '0;
                        n_chk       = 1'b0;
                        n_state     = ST_IDLE;
                    end else if (r_kc + CNT_W'(1) == r_loaded) begin
                        n_cur       = r_p;
                        n_cur_valid = 1'b1;
                        n_chk       = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_kc = r_kc + CNT_W'(1);
                    end
                end
            end

            ST_PICK_RD: begin
                bid_raddr = '0;
                n_ci      = '0;
                n_w1_vld  = 1'b0;
                n_w2_vld  = 1'b0;
                n_state   = ST_PICK_SCAN;
            end

            ST_PICK_SCAN: begin
                if (((cur_bid.strength >= wq) || pair) &&
                    (!r_w1_vld || (cur_bid.cost < r_best_cost))) begin
                    if (pair && r_w1_vld) begin
                        if (pair_sum >= {1'b0, wq}) begin
                            n_w2_vld    = 1'b1;
                            n_w2        = r_w1;
                            n_w1        = r_ci;
                            n_best_cost = cur_bid.cost;
                            n_best_str  = cur_bid.strength;
                        end
                    end else begin
                        n_w1_vld    = 1'b1;
                        n_w1        = r_ci;
                        n_best_cost = cur_bid.cost;
                        n_best_str  = cur_bid.strength;
                    end
                end
                n_ci = RB_W'(r_ci + RB_W'(1));
                if (r_ci == RB_W'(ROBOT_SLOTS - 1)) begin
                    n_bid_vld = '0;
                    n_bids    = '0;
                    if (!n_w1_vld || (pair && !n_w2_vld)) begin
                        n_state = ST_SRCH_START;
                    end else begin
                        n_active = (pair && (act_dec1 != 5'd0)) ? act_dec1 - 5'd1 : act_dec1;
                        task_we   = 1'b1;
                        n_out_vld = 1'b1;
                        n_kind    = KIND_WIN;
                        n_task    = 6'(r_cur);
                        n_first   = 5'({1'b0, n_w1} + (RB_W + 1)'(1));
                        n_second  = n_w2_vld ? 5'({1'b0, n_w2} + (RB_W + 1)'(1)) : 5'd0;
                        n_state   = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_out_vld;
    assign o_kind         = r_kind;
    assign o_task_res     = r_task;
    assign o_first_robot  = r_first;
    assign o_second_robot = r_second;

    `ATA_ASSERT_IMP(a_result_from_work, r_out_vld,
                    $past(r_state != ST_IDLE || start), "result without a transaction")
    `ATA_ASSERT_IMP(a_pointer_in_table, r_cur_valid,
                    {{(CNT_W-TK_W){1'b0}}, r_cur} < r_loaded,
                    "task pointer beyond loaded table")
    `ATA_ASSERT_IMP(a_win_on_current, r_out_vld && (r_kind == KIND_WIN),
                    r_cur_valid && (r_task == 6'(r_cur)), "win reported off the current task")
    `ATA_ASSERT_NXT(a_scan_clears_bids,
                    (r_state == ST_PICK_SCAN) && (r_ci == RB_W'(ROBOT_SLOTS - 1)),
                    (r_bids == 5'd0) && (r_bid_vld == '0), "bid store not cleared after round")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for auction_task_allocator_core: directed table, then random
// load/bid/complete traffic, each result checked against table or allocation predictor.
// Depends on ata_pkg and the auction_task_allocator_core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ata_pkg::*;

    localparam int FIN_MAX   = 511;
    localparam int IDLE_PCT  = 13;
    localparam int RAND_JOBS = 750;
    localparam int DIR_ROWS  = 25;

    localparam int CHK_MODEL = 0;
    localparam int CHK_NONE  = 1;
    localparam int CHK_RES   = 2;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  robot;
        logic [15:0] cost;
        logic [15:0] strength;
        logic [7:0]  weight;
        logic [1:0]  need;
        logic [4:0]  total;
        logic        fin;
    } t_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] task_id;
        logic [4:0] first_rb;
        logic [4:0] second_rb;
    } t_award;

    typedef struct {
        t_job   job;
        int     chk;
        t_award aw;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_robot = '0;
    logic [15:0] i_bid_cost = '0;
    logic [15:0] i_robot_strength = '0;
    logic [7:0]  i_task_weight = '0;
    logic [1:0]  i_robots_needed = '0;
    logic [4:0]  i_robot_total = '0;
    logic        i_final_task = 1'b0;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [5:0]  o_task_res;
    logic [4:0]  o_first_robot;
    logic [4:0]  o_second_robot;

    auction_task_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit [7:0]  wt_tab   [TASK_SLOTS];
    bit [1:0]  need_tab [TASK_SLOTS];
    bit        done_tab [TASK_SLOTS];
    int        tab_len = 0;
    int        load_ptr = 0;
    int        cur_ptr = 0;
    bit        cur_ok = 1'b0;
    int        fin_cnt = 0;
    bit [4:0]  bids_cnt = '0;
    bit [4:0]  act_cnt = '0;
    bit [15:0] cost_st [ROBOT_SLOTS];
    bit [15:0] str_st  [ROBOT_SLOTS];

    t_award awards_due[$];
    int     errors = 0;
    int     jobs_sent = 0;
    bit     calm = 1'b0;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{CMD_COMPLETE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_RES,
          '{KIND_ALL_DONE, 6'd0, 5'd0, 5'd0}},
        '{'{CMD_BID, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd2, 1'b0}, CHK_NONE, '0},
        '{'{CMD_BID, 4'd15, 16'hFFFF, 16'hFFFF, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd255, 2'd2, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd1, 2'd3, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd128, 2'd1, 5'd0, 1'b1}, CHK_RES,
          '{KIND_OFFER, 6'd0, 5'd0, 5'd0}},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd2, 1'b0}, CHK_NONE, '0},
        '{'{CMD_BID, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_NONE, '0},
        '{'{CMD_BID, 4'd15, 16'hFFFF, 16'hFFFF, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_RES,
          '{KIND_WIN, 6'd0, 5'd1, 5'd0}},
        '{'{CMD_COMPLETE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_RES,
          '{KIND_OFFER, 6'd1, 5'd0, 5'd0}},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd2, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd3, 16'd100, 16'h8000, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd7, 16'd50, 16'h7F00, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd16, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd2, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd5, 16'h0200, 16'hFFFF, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd6, 16'h0100, 16'h0100, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_COMPLETE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd1, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd9, 16'h1000, 16'h7FFF, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_ACTIVE, 4'd0, 16'd0, 16'd0, 8'd0, 2'd0, 5'd2, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd0, 16'h0200, 16'h8000, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0},
        '{'{CMD_BID, 4'd1, 16'h0100, 16'h7F00, 8'd0, 2'd0, 5'd0, 1'b0}, CHK_MODEL, '0}
    };

    function automatic void clear_round();
        for (int i = 0; i < ROBOT_SLOTS; i++) begin
            cost_st[i] = BID_IDLE;
            str_st[i]  = '0;
        end
        bids_cnt = '0;
    endfunction

    // round-robin search for the next open task
    function automatic void seek_open(output bit got, output t_award aw);
        int p, q;
        got = 1'b0;
        aw  = '0;
        if (tab_len == 0 || tab_len > TASK_SLOTS) begin
            cur_ok  = 1'b0;
            cur_ptr = 0;
            return;
        end
        p = cur_ok ? cur_ptr + 1 : 0;
        if (p >= tab_len) p = 0;
        for (int k = 0; k < tab_len; k++) begin
            q = p + k;
            if (q >= tab_len) q -= tab_len;
            if (!done_tab[q]) begin
                cur_ptr = q;
                cur_ok  = 1'b1;
                got     = 1'b1;
                aw      = '{KIND_OFFER, 6'(q), 5'd0, 5'd0};
                return;
            end
        end
        cur_ptr = p;
        cur_ok  = 1'b1;
    endfunction

    function automatic void close_round(output bit got, output t_award aw);
        int w1, w2, wq, str_sum;
        bit pair, ok;
        got = 1'b0;
        aw  = '0;
        w1  = -1;
        w2  = -1;
        if (!cur_ok || cur_ptr >= TASK_SLOTS) begin
            clear_round();
            seek_open(got, aw);
            return;
        end
        pair = (need_tab[cur_ptr] == PAIR_NEED);
        wq   = int'(wt_tab[cur_ptr]) << 8;
        for (int i = 0; i < ROBOT_SLOTS; i++) begin
            ok = (int'(str_st[i]) >= wq) || pair;
            if (!ok) continue;
            if (w1 == -1 || cost_st[i] < cost_st[w1]) begin
                // pair: new best only if it teams up with the previous best
                if (pair && w1 != -1) begin
                    str_sum = int'(str_st[i]) + int'(str_st[w1]);
                    if (str_sum < wq) continue;
                    w2 = w1;
                end
                w1 = i;
            end
        end
        clear_round();
        if (w1 == -1 || (pair && w2 == -1)) begin
            seek_open(got, aw);
            return;
        end
        if (act_cnt > 0) act_cnt--;
        if (pair && act_cnt > 0) act_cnt--;
        done_tab[cur_ptr] = 1'b1;
        got = 1'b1;
        aw  = '{KIND_WIN, 6'(cur_ptr), 5'(w1 + 1), 5'(w2 + 1)};
    endfunction

    function automatic void alloc_step(input t_job j, output bit got, output t_award aw);
        got = 1'b0;
        aw  = '0;
        case (j.cmd)
            CMD_LOAD: begin
                if (load_ptr < TASK_SLOTS) begin
                    wt_tab[load_ptr]   = j.weight;
                    need_tab[load_ptr] = j.need;
                    done_tab[load_ptr] = 1'b0;
                    load_ptr++;
                end
                if (j.fin) begin
                    tab_len  = load_ptr;
                    load_ptr = 0;
                    fin_cnt  = 0;
                    cur_ok   = 1'b0;
                    cur_ptr  = 0;
                    seek_open(got, aw);
                end
            end
            CMD_ACTIVE: act_cnt = j.total;
            CMD_BID: begin
                if (int'(j.robot) < ROBOT_SLOTS) begin
                    cost_st[j.robot] = j.cost;
                    str_st[j.robot]  = j.strength;
                end
                bids_cnt = bids_cnt + 5'd1;
                if (bids_cnt == act_cnt) close_round(got, aw);
            end
            CMD_COMPLETE: begin
                if (fin_cnt < FIN_MAX) fin_cnt++;
                if (fin_cnt < tab_len) begin
                    seek_open(got, aw);
                end else begin
                    got = 1'b1;
                    aw  = '{KIND_ALL_DONE, 6'd0, 5'd0, 5'd0};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_job rand_job(t_cmd c);
        t_job j;
        j.cmd      = c;
        j.robot    = 4'($urandom_range(0, 15));
        j.cost     = 16'($urandom);
        j.strength = 16'($urandom);
        j.weight   = 8'($urandom);
        j.need     = 2'($urandom);
        j.total    = 5'($urandom_range(0, 16));
        j.fin      = 1'b0;
        return j;
    endfunction

    function automatic logic [15:0] pick_cost();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom_range(0, 3));
            2:       return 16'hFFFF;
            3:       return BID_IDLE;
            default: return 16'($urandom);
        endcase
    endfunction

    // strengths near the offered task's weight so that wins and misses both occur
    function automatic logic [15:0] pick_strength();
        int  base, v;
        bit  live;
        live = cur_ok && cur_ptr < tab_len;
        base = live ? int'(wt_tab[cur_ptr]) << 8 : int'($urandom_range(0, 65535));
        if (live && need_tab[cur_ptr] == PAIR_NEED) base = base / 2;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: begin
                v = base + int'($urandom_range(0, 1024)) - 512;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    task automatic issue(input t_job j, input int chk, input t_award typed_aw);
        bit     got;
        t_award aw;
        start            <= 1'b1;
        i_cmd            <= j.cmd;
        i_robot          <= j.robot;
        i_bid_cost       <= j.cost;
        i_robot_strength <= j.strength;
        i_task_weight    <= j.weight;
        i_robots_needed  <= j.need;
        i_robot_total    <= j.total;
        i_final_task     <= j.fin;
        do @(posedge i_clk); while (busy);
        alloc_step(j, got, aw);
        if (chk == CHK_RES) awards_due.push_back(typed_aw);
        else if (chk == CHK_MODEL && got) awards_due.push_back(aw);
        jobs_sent++;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : chk_out
        t_award seen, want;
        if (i_rst_n && o_valid) begin
            seen = '{o_kind, o_task_res, o_first_robot, o_second_robot};
            if (awards_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind %0d task %0d robots %0d/%0d",
                             $realtime, seen.kind, seen.task_id, seen.first_rb, seen.second_rb);
            end else begin
                want = awards_due.pop_front();
                if (want != seen) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: mismatch exp kind %0d task %0d robots %0d/%0d",
                                 $realtime, want.kind, want.task_id, want.first_rb,
                                 want.second_rb,
                                 ", got kind %0d task %0d robots %0d/%0d",
                                 seen.kind, seen.task_id, seen.first_rb, seen.second_rb);
                end
            end
        end
    end

    initial begin
        t_job j;
        int   n, pick, act;
        bit   full_done, sat_done, paused, skip_act;
        full_done = 1'b0;
        sat_done  = 1'b0;
        paused    = 1'b0;
        clear_round();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            issue(dir_tab[r].job, dir_tab[r].chk, dir_tab[r].aw);

        while (jobs_sent < DIR_ROWS + RAND_JOBS) begin
            calm = (jobs_sent >= 300 && jobs_sent < 420);
            if (!sat_done && jobs_sent > 450) begin
                // long run of completions drives the RTL finished count into saturation
                sat_done = 1'b1;
                repeat (135) issue(rand_job(CMD_COMPLETE), CHK_MODEL, '0);
            end else if ((!paused && jobs_sent > 550) || $urandom_range(0, 99) < 2) begin
                paused = 1'b1;
                start <= 1'b0;
                @(posedge i_clk);
                while (awards_due.size() != 0) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    if (!full_done && jobs_sent > 150) begin
                        n = TASK_SLOTS + 2;
                        full_done = 1'b1;
                    end else if ($urandom_range(0, 9) == 0) begin
                        n = $urandom_range(9, TASK_SLOTS);
                    end else begin
                        n = $urandom_range(1, 8);
                    end
                    for (int k = 0; k < n; k++) begin
                        j = rand_job(CMD_LOAD);
                        j.fin = (k == n - 1);
                        issue(j, CHK_MODEL, '0);
                    end
                end else if (pick < 65) begin
                    pick     = $urandom_range(0, 99);
                    skip_act = 1'b0;
                    if (pick < 70) act = $urandom_range(1, 3);
                    else if (pick < 80) act = $urandom_range(4, 16);
                    else if (pick < 85) act = 0;
                    else skip_act = 1'b1;
                    if (!skip_act) begin
                        j = rand_job(CMD_ACTIVE);
                        j.total = 5'(act);
                        issue(j, CHK_MODEL, '0);
                    end
                    for (int b = 0; b < 32; b++) begin
                        j = rand_job(CMD_BID);
                        j.cost = pick_cost();
                        j.strength = pick_strength();
                        issue(j, CHK_MODEL, '0);
                        if (bids_cnt == 0) break;
                    end
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 3)) issue(rand_job(CMD_COMPLETE), CHK_MODEL, '0);
                end else begin
                    j = rand_job(t_cmd'($urandom_range(0, 3)));
                    j.fin = 1'($urandom_range(0, 1));
                    issue(j, CHK_MODEL, '0);
                end
            end
        end
        start <= 1'b0;

        while (awards_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- auction_task_allocator_core.f -----
+incdir+src
src/ata_pkg.sv
src/ata_ram.sv
src/auction_task_allocator_core.sv
tb/testbench.sv
